// ===== rtl/core/pis_pkg.sv =====
// shared constants, types and the cordic angle table for the point-in-sector test
// no dependencies; used by every module under rtl/core
package pis_pkg;

   // data path sizing
   localparam int COORD_BITS    = 16;
   localparam int ANGLE_BITS    = 16;
   localparam int CORDIC_STAGES = 16;
   localparam int GUARD_BITS    = 8;
   localparam int FIELD_BITS    = 16;
   localparam int RADIUS_BITS   = 16;
   localparam int TABLE_LEN     = 24;
   localparam int TABLE_SEL_BITS = 5;

   // cordic vector width: sign, coordinate difference, guard bits, gain headroom
   localparam int XY_BITS     = COORD_BITS + GUARD_BITS + 4;
   localparam int ANGLE_SHIFT = 32 - ANGLE_BITS;
   localparam int SQ_BITS     = 2 * RADIUS_BITS;
   localparam int CLOSE_BITS  = (COORD_BITS + 1 > RADIUS_BITS) ? COORD_BITS + 1 : RADIUS_BITS;
   localparam int CMP_BITS    = (ANGLE_BITS + 1 > FIELD_BITS + 1) ? ANGLE_BITS + 1
                                                                  : FIELD_BITS + 1;

   // register indexes of the configuration port
   localparam int CSR_INDEX_BITS = 1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_VIEW_RADIUS = 1'b0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_VIEW_WIDTH  = 1'b1;

   // reset values of the configuration registers
   localparam logic [FIELD_BITS-1:0] VIEW_RADIUS_RESET = 16'd100;
   localparam logic [FIELD_BITS-1:0] VIEW_WIDTH_RESET  = 16'd10923;

   // atan(2^-i) with a full turn of 2^32
   localparam logic [31:0] ATAN_TURN32 [TABLE_LEN] = '{
      32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
      32'd21354465,  32'd10679838,  32'd5340245,   32'd2670163,  32'd1335087,
      32'd667544,    32'd333772,    32'd166886,    32'd83443,    32'd41722,
      32'd20861,     32'd10430,     32'd5215,      32'd2608,     32'd1304,
      32'd652,       32'd326,       32'd163,       32'd81
   };

   // stage angle rounded half up to the angle width
   function automatic logic [ANGLE_BITS-1:0] stage_angle(input logic [TABLE_SEL_BITS-1:0] sel);
      logic [32:0] t;
      t = {1'b0, ATAN_TURN32[sel]} + (33'd1 << (ANGLE_SHIFT - 1));
      return ANGLE_BITS'(t >> ANGLE_SHIFT);
   endfunction

   // side information that rides along the cordic pipeline
   typedef struct packed {
      logic                  zero;
      logic                  in_range;
      logic [ANGLE_BITS-1:0] facing;
   } tag_type;

   // one cordic lane
   typedef struct packed {
      logic signed [XY_BITS-1:0] x;
      logic signed [XY_BITS-1:0] y;
      logic [ANGLE_BITS-1:0]     z;
      tag_type                   tag;
   } cordic_type;

   // one result item
   typedef struct packed {
      logic                         in_view;
      logic                         in_range;
      logic signed [FIELD_BITS-1:0] angle_offset;
   } rsp_type;

endpackage

// ===== rtl/core/point_in_sector_test.sv =====
// point-in-sector test: req_ items carry a test point, a viewer centre and a
// facing angle; each gives one rsp_ item with in_view, in_range and the signed
// bearing offset. Both channels are valid/ready; an item moves at a clock edge
// with valid and ready high. The csr_ port writes view_radius (index 0) and
// view_width (index 1) at any edge with csr_write_en high; write only while idle.
// Throughput: one item per cycle while the skid register is empty. An accepted
// item passes to rsp_valid through four front stages (difference, magnitude,
// squares, range compare), sixteen cordic stages (one micro-rotation each),
// two back stages and the output register.
// Reset (synchronous, active high) empties the pipeline, clears both output
// slots and loads view_radius 100 and view_width 10923.
// When the receiver stalls, the output register holds its item and the next
// finished item drops into a one-entry skid register; req_ready stays high
// until that skid register fills, then the whole pipeline freezes, losing and
// repeating nothing, and resumes as soon as the receiver takes an item.
// Uses pis_pkg, pis_front, pis_cordic and pis_back.
module point_in_sector_test (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      req_valid,
   output logic                                      req_ready,
   input  logic signed [pis_pkg::COORD_BITS-1:0]     req_point_x,
   input  logic signed [pis_pkg::COORD_BITS-1:0]     req_point_y,
   input  logic signed [pis_pkg::COORD_BITS-1:0]     req_center_x,
   input  logic signed [pis_pkg::COORD_BITS-1:0]     req_center_y,
   input  logic [pis_pkg::FIELD_BITS-1:0]            req_facing_angle,
   output logic                                      rsp_valid,
   input  logic                                      rsp_ready,
   output logic                                      rsp_in_view,
   output logic                                      rsp_in_range,
   output logic signed [pis_pkg::FIELD_BITS-1:0]     rsp_angle_offset,
   input  logic                                      csr_write_en,
   input  logic [pis_pkg::CSR_INDEX_BITS-1:0]        csr_index,
   input  logic [pis_pkg::FIELD_BITS-1:0]            csr_wdata
);

   logic [pis_pkg::FIELD_BITS-1:0] radius_ff, radius_in;
   logic [pis_pkg::FIELD_BITS-1:0] width_ff, width_in;

   logic                en;
   logic                front_valid, cordic_valid, back_valid;
   pis_pkg::cordic_type front_data, cordic_data;
   pis_pkg::rsp_type    back_data;

   logic                out_valid_ff, out_valid_in;
   logic                skid_valid_ff, skid_valid_in;
   pis_pkg::rsp_type    out_data_ff, out_data_in;
   pis_pkg::rsp_type    skid_data_ff, skid_data_in;

   // configuration register decode
   always_comb begin
      radius_in = radius_ff;
      width_in  = width_ff;
      if (csr_write_en) begin
         unique case (csr_index)
            pis_pkg::CSR_VIEW_RADIUS: radius_in = csr_wdata;
            pis_pkg::CSR_VIEW_WIDTH:  width_in  = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff <= pis_pkg::VIEW_RADIUS_RESET;
         width_ff  <= pis_pkg::VIEW_WIDTH_RESET;
      end else begin
         radius_ff <= radius_in;
         width_ff  <= width_in;
      end
   end

   // the pipeline moves whenever the skid slot is free
   assign en        = !skid_valid_ff;
   assign req_ready = en;

   pis_front u_front (
      .clock        (clock),
      .reset        (reset),
      .en           (en),
      .in_valid     (req_valid),
      .point_x      (req_point_x),
      .point_y      (req_point_y),
      .center_x     (req_center_x),
      .center_y     (req_center_y),
      .facing_angle (req_facing_angle),
      .view_radius  (radius_ff),
      .out_valid    (front_valid),
      .out_data     (front_data)
   );

   pis_cordic u_cordic (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (front_valid),
      .in_data   (front_data),
      .out_valid (cordic_valid),
      .out_data  (cordic_data)
   );

   pis_back u_back (
      .clock      (clock),
      .reset      (reset),
      .en         (en),
      .in_valid   (cordic_valid),
      .in_data    (cordic_data),
      .view_width (width_ff),
      .out_valid  (back_valid),
      .out_data   (back_data)
   );

   // output register with one-entry skid
   always_comb begin
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      out_data_in   = out_data_ff;
      skid_data_in  = skid_data_ff;
      if (skid_valid_ff) begin
         if (rsp_ready) begin
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end
      end else if (back_valid) begin
         if (!out_valid_ff || rsp_ready) begin
            out_data_in  = back_data;
            out_valid_in = 1'b1;
         end else begin
            skid_data_in  = back_data;
            skid_valid_in = 1'b1;
         end
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_in_view      = out_data_ff.in_view;
   assign rsp_in_range     = out_data_ff.in_range;
   assign rsp_angle_offset = out_data_ff.angle_offset;

   // skid slot is only ever filled behind a held output item
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid holds an item while the output register is empty");

   // the skid slot fills only when the receiver stalled a waiting item
   a_skid_fill_on_stall: assert property (@(posedge clock) disable iff (reset)
      $rose(skid_valid_ff) |-> $past(out_valid_ff && !rsp_ready && back_valid))
      else $error("skid filled without a stalled output item");

   // in view implies in range
   a_view_needs_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (!rsp_in_view || rsp_in_range))
      else $error("in_view set on an out-of-range item");

   // a draining skid hands its item to the output register
   a_skid_drain: assert property (@(posedge clock) disable iff (reset)
      (skid_valid_ff && rsp_ready) |=> (out_valid_ff && !skid_valid_ff))
      else $error("skid item lost on drain");

endmodule

// ===== rtl/core/pis_front.sv =====
// front end: coordinate differences, exact range test and cordic pre-rotation
// four register stages; uses pis_pkg
module pis_front (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   en,
   input  logic                                   in_valid,
   input  logic signed [pis_pkg::COORD_BITS-1:0]  point_x,
   input  logic signed [pis_pkg::COORD_BITS-1:0]  point_y,
   input  logic signed [pis_pkg::COORD_BITS-1:0]  center_x,
   input  logic signed [pis_pkg::COORD_BITS-1:0]  center_y,
   input  logic [pis_pkg::FIELD_BITS-1:0]         facing_angle,
   input  logic [pis_pkg::FIELD_BITS-1:0]         view_radius,
   output logic                                   out_valid,
   output pis_pkg::cordic_type                    out_data
);

   localparam int C = pis_pkg::COORD_BITS;
   localparam int A = pis_pkg::ANGLE_BITS;
   localparam int R = pis_pkg::RADIUS_BITS;

   // stage 1 registers
   logic                  f1_valid_ff;
   logic signed [C:0]     f1_dx_ff, f1_dx_in;
   logic signed [C:0]     f1_dy_ff, f1_dy_in;
   logic [A-1:0]          f1_facing_ff;

   // stage 2 registers
   logic                  f2_valid_ff;
   logic [R-1:0]          f2_sx_ff, f2_sx_in;
   logic [R-1:0]          f2_sy_ff, f2_sy_in;
   logic                  f2_close_ff, f2_close_in;
   logic signed [C+1:0]   f2_x0_ff, f2_x0_in;
   logic signed [C+1:0]   f2_y0_ff, f2_y0_in;
   logic [A-1:0]          f2_z0_ff, f2_z0_in;
   logic                  f2_zero_ff, f2_zero_in;
   logic [A-1:0]          f2_facing_ff;

   // stage 3 registers
   logic                       f3_valid_ff;
   logic [pis_pkg::SQ_BITS-1:0] f3_sqx_ff, f3_sqy_ff, f3_rr_ff;
   logic                       f3_close_ff;
   logic signed [C+1:0]        f3_x0_ff, f3_y0_ff;
   logic [A-1:0]               f3_z0_ff;
   logic                       f3_zero_ff;
   logic [A-1:0]               f3_facing_ff;

   // stage 4 registers
   logic                  f4_valid_ff;
   logic                  f4_range_ff, f4_range_in;
   logic signed [C+1:0]   f4_x0_ff, f4_y0_ff;
   logic [A-1:0]          f4_z0_ff;
   logic                  f4_zero_ff;
   logic [A-1:0]          f4_facing_ff;

   logic [C:0]            ax, ay;
   logic signed [C+1:0]   dy_wide;
   logic signed [pis_pkg::XY_BITS-1:0] x_ext, y_ext;
   logic [pis_pkg::SQ_BITS:0] sq_sum;

   // differences, one bit wider than a coordinate
   assign f1_dx_in = $signed({point_x[C-1], point_x}) - $signed({center_x[C-1], center_x});
   assign f1_dy_in = $signed({point_y[C-1], point_y}) - $signed({center_y[C-1], center_y});

   // magnitudes, coarse range check and pre-rotation into the right half plane
   always_comb begin
      ax          = f1_dx_ff[C] ? (~f1_dx_ff + 1'b1) : f1_dx_ff;
      ay          = f1_dy_ff[C] ? (~f1_dy_ff + 1'b1) : f1_dy_ff;
      f2_close_in = (pis_pkg::CLOSE_BITS'(ax) <= pis_pkg::CLOSE_BITS'(view_radius)) &&
                    (pis_pkg::CLOSE_BITS'(ay) <= pis_pkg::CLOSE_BITS'(view_radius));
      f2_sx_in    = R'(ax);
      f2_sy_in    = R'(ay);
      dy_wide     = (C+2)'(f1_dy_ff);
      f2_x0_in    = $signed({1'b0, ax});
      f2_y0_in    = f1_dx_ff[C] ? -dy_wide : dy_wide;
      f2_z0_in    = f1_dx_ff[C] ? (A'(1) << (A - 1)) : '0;
      f2_zero_in  = (f1_dx_ff == '0) && (f1_dy_ff == '0);
   end

   // exact squared distance against squared radius
   assign sq_sum      = {1'b0, f3_sqx_ff} + {1'b0, f3_sqy_ff};
   assign f4_range_in = f3_close_ff && (sq_sum <= {1'b0, f3_rr_ff});

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         f1_valid_ff <= 1'b0;
         f2_valid_ff <= 1'b0;
         f3_valid_ff <= 1'b0;
         f4_valid_ff <= 1'b0;
      end else if (en) begin
         f1_valid_ff <= in_valid;
         f2_valid_ff <= f1_valid_ff;
         f3_valid_ff <= f2_valid_ff;
         f4_valid_ff <= f3_valid_ff;
      end
   end

   // payload stages
   always_ff @(posedge clock) begin
      if (en) begin
         f1_dx_ff     <= f1_dx_in;
         f1_dy_ff     <= f1_dy_in;
         f1_facing_ff <= A'(facing_angle);

         f2_sx_ff     <= f2_sx_in;
         f2_sy_ff     <= f2_sy_in;
         f2_close_ff  <= f2_close_in;
         f2_x0_ff     <= f2_x0_in;
         f2_y0_ff     <= f2_y0_in;
         f2_z0_ff     <= f2_z0_in;
         f2_zero_ff   <= f2_zero_in;
         f2_facing_ff <= f1_facing_ff;

         f3_sqx_ff    <= f2_sx_ff * f2_sx_ff;
         f3_sqy_ff    <= f2_sy_ff * f2_sy_ff;
         f3_rr_ff     <= R'(view_radius) * R'(view_radius);
         f3_close_ff  <= f2_close_ff;
         f3_x0_ff     <= f2_x0_ff;
         f3_y0_ff     <= f2_y0_ff;
         f3_z0_ff     <= f2_z0_ff;
         f3_zero_ff   <= f2_zero_ff;
         f3_facing_ff <= f2_facing_ff;

         f4_range_ff  <= f4_range_in;
         f4_x0_ff     <= f3_x0_ff;
         f4_y0_ff     <= f3_y0_ff;
         f4_z0_ff     <= f3_z0_ff;
         f4_zero_ff   <= f3_zero_ff;
         f4_facing_ff <= f3_facing_ff;
      end
   end

   // scale up by the guard bits for the cordic
   always_comb begin
      x_ext                 = pis_pkg::XY_BITS'(f4_x0_ff);
      y_ext                 = pis_pkg::XY_BITS'(f4_y0_ff);
      out_data.x            = x_ext <<< pis_pkg::GUARD_BITS;
      out_data.y            = y_ext <<< pis_pkg::GUARD_BITS;
      out_data.z            = f4_z0_ff;
      out_data.tag.zero     = f4_zero_ff;
      out_data.tag.in_range = f4_range_ff;
      out_data.tag.facing   = f4_facing_ff;
   end

   assign out_valid = f4_valid_ff;

endmodule

// ===== rtl/core/pis_cordic.sv =====
// unrolled vectoring cordic, one micro-rotation per register stage
// uses pis_pkg for widths, the angle table and the lane type
module pis_cordic (
   input  logic                clock,
   input  logic                reset,
   input  logic                en,
   input  logic                in_valid,
   input  pis_pkg::cordic_type in_data,
   output logic                out_valid,
   output pis_pkg::cordic_type out_data
);

   localparam int N = pis_pkg::CORDIC_STAGES;

   pis_pkg::cordic_type stage_ff [N];
   logic                valid_ff [N];
   pis_pkg::cordic_type stage_d  [N+1];
   logic                valid_d  [N+1];

   assign stage_d[0] = in_data;
   assign valid_d[0] = in_valid;

   for (genvar i = 0; i < N; i++) begin : g_stage
      pis_pkg::cordic_type               stage_in;
      logic signed [pis_pkg::XY_BITS-1:0] x_cur, y_cur, xs, ys;
      logic [pis_pkg::ANGLE_BITS-1:0]     ang;

      // rotate toward the x axis, steering on the sign of y
      always_comb begin
         x_cur    = stage_d[i].x;
         y_cur    = stage_d[i].y;
         xs       = x_cur >>> i;
         ys       = y_cur >>> i;
         ang      = pis_pkg::stage_angle(pis_pkg::TABLE_SEL_BITS'(i));
         stage_in = stage_d[i];
         if (!y_cur[pis_pkg::XY_BITS-1]) begin
            stage_in.x = x_cur + ys;
            stage_in.y = y_cur - xs;
            stage_in.z = stage_d[i].z + ang;
         end else begin
            stage_in.x = x_cur - ys;
            stage_in.y = y_cur + xs;
            stage_in.z = stage_d[i].z - ang;
         end
      end

      // stage valid bit
      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[i] <= 1'b0;
         end else if (en) begin
            valid_ff[i] <= valid_d[i];
         end
      end

      // stage payload
      always_ff @(posedge clock) begin
         if (en) begin
            stage_ff[i] <= stage_in;
         end
      end

      assign stage_d[i+1] = stage_ff[i];
      assign valid_d[i+1] = valid_ff[i];
   end

   assign out_data  = stage_d[N];
   assign out_valid = valid_d[N];

endmodule

// ===== rtl/core/pis_back.sv =====
// back end: bearing minus facing, wrap to signed and the half-width compare
// two register stages; uses pis_pkg
module pis_back (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           en,
   input  logic                           in_valid,
   input  pis_pkg::cordic_type            in_data,
   input  logic [pis_pkg::FIELD_BITS-1:0] view_width,
   output logic                           out_valid,
   output pis_pkg::rsp_type               out_data
);

   localparam int A = pis_pkg::ANGLE_BITS;

   logic                b1_valid_ff;
   logic [A-1:0]        b1_off_ff, b1_off_in;
   logic                b1_range_ff;
   logic                b2_valid_ff;
   pis_pkg::rsp_type    b2_data_ff, b2_data_in;
   logic [A-1:0]        bear;
   logic [A-1:0]        mag;

   // a point at the centre has bearing zero
   assign bear      = in_data.tag.zero ? '0 : in_data.z;
   assign b1_off_in = bear - in_data.tag.facing;

   // magnitude of the wrapped offset; a half turn stays a half turn
   always_comb begin
      mag                     = b1_off_ff[A-1] ? (~b1_off_ff + 1'b1) : b1_off_ff;
      b2_data_in.in_range     = b1_range_ff;
      b2_data_in.in_view      = b1_range_ff &&
                                (pis_pkg::CMP_BITS'({mag, 1'b0}) <=
                                 pis_pkg::CMP_BITS'(view_width));
      b2_data_in.angle_offset = pis_pkg::FIELD_BITS'($signed(b1_off_ff));
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         b1_valid_ff <= 1'b0;
         b2_valid_ff <= 1'b0;
      end else if (en) begin
         b1_valid_ff <= in_valid;
         b2_valid_ff <= b1_valid_ff;
      end
   end

   // payload stages
   always_ff @(posedge clock) begin
      if (en) begin
         b1_off_ff   <= b1_off_in;
         b1_range_ff <= in_data.tag.in_range;
         b2_data_ff  <= b2_data_in;
      end
   end

   assign out_valid = b2_valid_ff;
   assign out_data  = b2_data_ff;

endmodule
